### sv/pwq_pkg.sv
// ----------------------------------------------------------------------------
// pwq_pkg
// Shared types and codes for the priority-ordered wait queue: command and
// status codes, the queue entry and the per-cycle control word of a cell.
// ----------------------------------------------------------------------------
package pwq_pkg;

  localparam int QUEUE_DEPTH    = 16;
  localparam int THREAD_ID_BITS = 8;

  localparam logic [1:0] CMD_ENQUEUE  = 2'd0;
  localparam logic [1:0] CMD_WAKE_ONE = 2'd1;
  localparam logic [1:0] CMD_WAKE_ALL = 2'd2;
  localparam logic [1:0] CMD_CANCEL   = 2'd3;

  localparam logic [2:0] STATUS_WOKEN     = 3'd0;
  localparam logic [2:0] STATUS_ENQUEUED  = 3'd1;
  localparam logic [2:0] STATUS_EMPTY     = 3'd2;
  localparam logic [2:0] STATUS_FULL      = 3'd3;
  localparam logic [2:0] STATUS_CANCELLED = 3'd4;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd5;

  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_SHIFT  = 2'd2;
  localparam logic [1:0] CELL_CANCEL = 2'd3;

  typedef logic [THREAD_ID_BITS-1:0] tid_t;
  typedef logic [7:0]                prio_t;

  typedef struct packed {
    logic  valid;
    tid_t  id;
    prio_t prio;
  } entry_t;

  typedef struct packed {
    logic [1:0] op;
    tid_t       id;
    prio_t      prio;
  } cell_ctl_t;

endpackage

### sv/priority_wait_queue.sv
// ----------------------------------------------------------------------------
// priority_wait_queue
// Wait queue of thread ids kept in priority order in a row of cells.
// ----------------------------------------------------------------------------
// An enqueue, a wake-one and a cancel each give one result beat, and the next
// command is taken as soon as the output register is empty or being emptied,
// so one command per cycle is sustained when the output is not stalled. A
// wake-all on a queue of N waiters gives N beats, one per cycle while the
// output is not stalled, in service order, and holds off new commands until
// its final beat (marked by last) has entered the output register. The queue
// holds QUEUE_DEPTH waiters; an enqueue into a full queue is refused with a
// status beat and leaves the queue unchanged.
// ----------------------------------------------------------------------------
module priority_wait_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  thread_id,
  input  logic [7:0]  priority_req,
  input  logic [31:0] reason,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  woken_id,
  output logic [31:0] wake_reason,
  output logic [2:0]  status,
  output logic        last
);
  import pwq_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic                   state;
  logic                   state_next;
  logic [31:0]            drain_reason;
  entry_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ins;
  logic [QUEUE_DEPTH-1:0] hit;
  cell_ctl_t              ctl;
  logic                   out_free;
  logic                   accept;
  logic                   load;
  tid_t                   res_id;
  logic [31:0]            res_reason;
  logic [2:0]             res_status;
  logic                   res_last;
  logic                   full;
  logic                   empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   ins_prev;
    logic   hit_prev;
    if (i == 0) begin : g_head
      assign left_e   = '0;
      assign ins_prev = 1'b0;
      assign hit_prev = 1'b0;
    end else begin : g_body
      assign left_e   = entries[i-1];
      assign ins_prev = ins[i-1];
      assign hit_prev = hit[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_mid
      assign right_e = entries[i+1];
    end
    pwq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .left    (left_e),
      .right   (right_e),
      .ins_in  (ins_prev),
      .hit_in  (hit_prev),
      .ins_out (ins[i]),
      .hit_out (hit[i]),
      .entry   (entries[i])
    );
  end

  assign full     = entries[QUEUE_DEPTH-1].valid;
  assign empty    = !entries[0].valid;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    load       = 1'b0;
    ctl.op     = CELL_HOLD;
    ctl.id     = thread_id[THREAD_ID_BITS-1:0];
    ctl.prio   = priority_req;
    res_id     = ctl.id;
    res_reason = 32'd0;
    res_status = STATUS_ENQUEUED;
    res_last   = 1'b1;
    if (accept) begin
      load = 1'b1;
      unique case (command)
        CMD_ENQUEUE: begin
          if (full) begin
            res_status = STATUS_FULL;
          end else begin
            ctl.op     = CELL_INSERT;
            res_status = STATUS_ENQUEUED;
          end
        end
        CMD_WAKE_ONE, CMD_WAKE_ALL: begin
          if (empty) begin
            res_id     = '0;
            res_status = STATUS_EMPTY;
          end else begin
            ctl.op     = CELL_SHIFT;
            res_id     = entries[0].id;
            res_reason = reason;
            res_status = STATUS_WOKEN;
            if (command == CMD_WAKE_ALL && entries[1].valid) begin
              res_last   = 1'b0;
              state_next = S_DRAIN;
            end
          end
        end
        CMD_CANCEL: begin
          ctl.op     = CELL_CANCEL;
          res_status = hit[QUEUE_DEPTH-1] ? STATUS_CANCELLED : STATUS_NOT_FOUND;
        end
        default: begin
          ctl.op = CELL_HOLD;
        end
      endcase
    end else if (state == S_DRAIN && out_free) begin
      load       = 1'b1;
      ctl.op     = CELL_SHIFT;
      res_id     = entries[0].id;
      res_reason = drain_reason;
      res_status = STATUS_WOKEN;
      res_last   = !entries[1].valid;
      if (res_last) begin
        state_next = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      drain_reason <= reason;
    end
    if (load) begin
      woken_id    <= 8'(res_id);
      wake_reason <= res_reason;
      status      <= res_status;
      last        <= res_last;
    end
  end

endmodule

### sv/pwq_cell.sv
// ----------------------------------------------------------------------------
// pwq_cell
// One slot of the sorted wait queue. It holds a single waiter and, as the
// command says, keeps it, takes the new waiter, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module pwq_cell (
  input  logic               clk,
  input  logic               rst,
  input  pwq_pkg::cell_ctl_t ctl,
  input  pwq_pkg::entry_t    left,
  input  pwq_pkg::entry_t    right,
  input  logic               ins_in,
  input  logic               hit_in,
  output logic               ins_out,
  output logic               hit_out,
  output pwq_pkg::entry_t    entry
);
  import pwq_pkg::*;

  entry_t entry_next;
  logic   ins;
  logic   match;

  assign ins     = !entry.valid || (ctl.prio > entry.prio);
  assign match   = entry.valid && (entry.id == ctl.id);
  assign ins_out = ins;
  assign hit_out = hit_in || match;

  always_comb begin
    entry_next = entry;
    case (ctl.op)
      CELL_INSERT: begin
        if (ins && ins_in) begin
          entry_next = left;
        end else if (ins) begin
          entry_next = '{valid: 1'b1, id: ctl.id, prio: ctl.prio};
        end
      end
      CELL_SHIFT: begin
        entry_next = right;
      end
      CELL_CANCEL: begin
        if (hit_in || match) begin
          entry_next = right;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.id   <= entry_next.id;
    entry.prio <= entry_next.prio;
  end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the priority-ordered wait queue. A short table
// of directed commands covers the empty, full, duplicate, equal-priority and
// cancel cases, and then several hundred random commands follow under
// different amounts of sender idling and receiver stalling. Every result beat
// is checked field by field against its table row or a behavioral model of the sorted queue.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwq_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 125;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] why;
    logic [2:0]  st;
    logic        fin;
  } beat_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  tid;
    logic [7:0]  prio;
    logic [31:0] why;
    bit          typed;
    beat_t       want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_ENQUEUE;
  logic [7:0]  thread_id = 8'h00;
  logic [7:0]  priority_req = 8'h00;
  logic [31:0] reason = 32'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  woken_id;
  logic [31:0] wake_reason;
  logic [2:0]  status;
  logic        last;

  tid_t      waiter_id [QUEUE_DEPTH];
  prio_t     waiter_prio [QUEUE_DEPTH];
  int        waiter_total = 0;
  beat_t     fresh_beats [$];
  beat_t     pending_beats [$];
  plan_row_t directed_plan [$];

  int errors = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit fill_mode = 1'b0;
  int cmds_sent = 0;
  int beats_checked = 0;
  int full_refusals = 0;
  int cancel_hits = 0;
  int cancel_misses = 0;
  int empty_wakes = 0;
  int widest_burst = 0;

  priority_wait_queue dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .thread_id    (thread_id),
    .priority_req (priority_req),
    .reason       (reason),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .woken_id     (woken_id),
    .wake_reason  (wake_reason),
    .status       (status),
    .last         (last)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  function automatic beat_t make_beat(logic [7:0] id, logic [31:0] why, logic [2:0] st,
                                      logic fin);
    beat_t b;
    b.id  = id;
    b.why = why;
    b.st  = st;
    b.fin = fin;
    return b;
  endfunction

  function automatic void drop_waiter(int pos);
    int i;
    for (i = pos; i + 1 < waiter_total; i++) begin
      waiter_id[i]   = waiter_id[i + 1];
      waiter_prio[i] = waiter_prio[i + 1];
    end
    waiter_total--;
  endfunction

  function automatic void queue_step(logic [1:0] cmd, logic [7:0] tid, logic [7:0] prio,
                                     logic [31:0] why);
    tid_t key;
    int   pos;
    int   i;
    bit   hit;
    key = tid;
    fresh_beats.delete();
    case (cmd)
      CMD_ENQUEUE: begin
        if (waiter_total >= QUEUE_DEPTH) begin
          fresh_beats.push_back(make_beat(key, 32'h0, STATUS_FULL, 1'b1));
          full_refusals++;
        end else begin
          pos = 0;
          while (pos < waiter_total && !(prio > waiter_prio[pos])) pos++;
          for (i = waiter_total; i > pos; i--) begin
            waiter_id[i]   = waiter_id[i - 1];
            waiter_prio[i] = waiter_prio[i - 1];
          end
          waiter_id[pos]   = key;
          waiter_prio[pos] = prio;
          waiter_total++;
          fresh_beats.push_back(make_beat(key, 32'h0, STATUS_ENQUEUED, 1'b1));
        end
      end
      CMD_WAKE_ONE, CMD_WAKE_ALL: begin
        if (waiter_total == 0) begin
          fresh_beats.push_back(make_beat(8'h00, 32'h0, STATUS_EMPTY, 1'b1));
          empty_wakes++;
        end else if (cmd == CMD_WAKE_ONE) begin
          fresh_beats.push_back(make_beat(waiter_id[0], why, STATUS_WOKEN, 1'b1));
          drop_waiter(0);
        end else begin
          for (i = 0; i < waiter_total; i++) begin
            fresh_beats.push_back(make_beat(waiter_id[i], why, STATUS_WOKEN,
                                            i + 1 == waiter_total));
          end
          if (waiter_total > widest_burst) widest_burst = waiter_total;
          waiter_total = 0;
        end
      end
      default: begin
        hit = 1'b0;
        for (pos = 0; pos < waiter_total && !hit; pos++) begin
          if (waiter_id[pos] == key) begin
            drop_waiter(pos);
            hit = 1'b1;
          end
        end
        fresh_beats.push_back(make_beat(key, 32'h0, hit ? STATUS_CANCELLED : STATUS_NOT_FOUND,
                                        1'b1));
        if (hit) cancel_hits++;
        else cancel_misses++;
      end
    endcase
  endfunction

  function automatic void add_row(logic [1:0] cmd, logic [7:0] tid, logic [7:0] prio,
                                  logic [31:0] why, bit typed, logic [7:0] want_id,
                                  logic [2:0] want_st);
    plan_row_t r;
    r.cmd   = cmd;
    r.tid   = tid;
    r.prio  = prio;
    r.why   = why;
    r.typed = typed;
    r.want  = make_beat(want_id, 32'h0, want_st, 1'b1);
    directed_plan.push_back(r);
  endfunction

  function automatic void build_plan();
    int i;
    add_row(CMD_WAKE_ONE, 8'h00, 8'h00, 32'hFFFFFFFF, 1'b1, 8'h00, STATUS_EMPTY);
    add_row(CMD_WAKE_ALL, 8'hFF, 8'hFF, 32'hFFFFFFFF, 1'b1, 8'h00, STATUS_EMPTY);
    add_row(CMD_CANCEL,   8'hFF, 8'h00, 32'hFFFFFFFF, 1'b1, 8'hFF, STATUS_NOT_FOUND);
    add_row(CMD_ENQUEUE,  8'h00, 8'h00, 32'hFFFFFFFF, 1'b1, 8'h00, STATUS_ENQUEUED);
    add_row(CMD_ENQUEUE,  8'hFF, 8'hFF, 32'h0,        1'b1, 8'hFF, STATUS_ENQUEUED);
    add_row(CMD_ENQUEUE,  8'h12, 8'h80, 32'h0,        1'b1, 8'h12, STATUS_ENQUEUED);
    add_row(CMD_ENQUEUE,  8'h34, 8'h80, 32'h0,        1'b1, 8'h34, STATUS_ENQUEUED);
    add_row(CMD_ENQUEUE,  8'h12, 8'h01, 32'h0,        1'b1, 8'h12, STATUS_ENQUEUED);
    add_row(CMD_WAKE_ONE, 8'h00, 8'h00, 32'hFFFFFFFF, 1'b0, 8'h00, STATUS_WOKEN);
    add_row(CMD_CANCEL,   8'h12, 8'h00, 32'h0,        1'b1, 8'h12, STATUS_CANCELLED);
    add_row(CMD_CANCEL,   8'h77, 8'h00, 32'h0,        1'b1, 8'h77, STATUS_NOT_FOUND);
    for (i = 0; i < QUEUE_DEPTH - 3; i++) begin
      add_row(CMD_ENQUEUE, 8'(8'h40 + i), 8'(i * 53), 32'(i), 1'b1, 8'(8'h40 + i),
              STATUS_ENQUEUED);
    end
    add_row(CMD_ENQUEUE,  8'hAA, 8'hFF, 32'hFFFFFFFF, 1'b1, 8'hAA, STATUS_FULL);
    add_row(CMD_WAKE_ALL, 8'h00, 8'h00, 32'h5A5AA5A5, 1'b0, 8'h00, STATUS_WOKEN);
  endfunction

  task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] tid,
                          input logic [7:0] prio, input logic [31:0] why,
                          input bit typed, input beat_t want);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    thread_id    <= tid;
    priority_req <= prio;
    reason       <= why;
    do @(posedge clk); while (in_stall);
    queue_step(cmd, tid, prio, why);
    if (typed) pending_beats.push_back(want);
    else foreach (fresh_beats[i]) pending_beats.push_back(fresh_beats[i]);
    cmds_sent++;
  endtask

  task automatic pick_cmd(output logic [1:0] cmd, output logic [7:0] tid,
                          output logic [7:0] prio, output logic [31:0] why);
    int r;
    int enq_w;
    int one_w;
    int all_w;
    r     = $urandom_range(99);
    enq_w = fill_mode ? 80 : 40;
    one_w = fill_mode ? 6 : 16;
    all_w = fill_mode ? 3 : 8;
    if (r < enq_w) cmd = CMD_ENQUEUE;
    else if (r < enq_w + one_w) cmd = CMD_WAKE_ONE;
    else if (r < enq_w + one_w + all_w) cmd = CMD_WAKE_ALL;
    else cmd = CMD_CANCEL;
    tid  = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    prio = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    why  = $urandom;
    if (cmd == CMD_CANCEL && waiter_total > 0 && $urandom_range(99) < 70) begin
      tid = waiter_id[$urandom_range(waiter_total - 1)];
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = make_beat(woken_id, wake_reason, status, last);
        if (pending_beats.size() == 0) begin
          $display("%0t: unexpected beat id %h reason %h status %0d last %b", $time,
                   got.id, got.why, got.st, got.fin);
          errors++;
        end else begin
          want = pending_beats.pop_front();
          if (got.id !== want.id) begin
            $display("%0t: woken_id expected %h got %h", $time, want.id, got.id);
            errors++;
          end
          if (got.why !== want.why) begin
            $display("%0t: wake_reason expected %h got %h", $time, want.why, got.why);
            errors++;
          end
          if (got.st !== want.st) begin
            $display("%0t: status expected %0d got %0d", $time, want.st, got.st);
            errors++;
          end
          if (got.fin !== want.fin) begin
            $display("%0t: last expected %b got %b", $time, want.fin, got.fin);
            errors++;
          end
        end
        beats_checked++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL priority_wait_queue");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0]  cmd;
    logic [7:0]  tid;
    logic [7:0]  prio;
    logic [31:0] why;
    int          phase;
    int          n;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    build_plan();
    foreach (directed_plan[i]) begin
      send_cmd(directed_plan[i].cmd, directed_plan[i].tid, directed_plan[i].prio,
               directed_plan[i].why, directed_plan[i].typed, directed_plan[i].want);
    end
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 32 == 0) fill_mode = 1'($urandom_range(1));
        pick_cmd(cmd, tid, prio, why);
        send_cmd(cmd, tid, prio, why, 1'b0, make_beat(8'h00, 32'h0, STATUS_WOKEN, 1'b0));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (pending_beats.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, pending_beats.size());
      errors++;
    end
    $display("Sent %0d commands and checked %0d result beats; widest wake-all was %0d beats.",
             cmds_sent, beats_checked, widest_burst);
    $display("Saw %0d full refusals, %0d cancel hits, %0d cancel misses, %0d empty wakes.",
             full_refusals, cancel_hits, cancel_misses, empty_wakes);
    if (errors == 0) begin
      $display("PASS priority_wait_queue");
    end else begin
      $display("FAIL priority_wait_queue");
    end
    $finish;
  end

endmodule
